/* sv/rbsi_pkg.sv */
// shared constants and types for the ray box slab test
package rbsi_pkg;

  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned NumAxes      = 3;
  localparam int unsigned NumRegs      = 6;
  localparam int unsigned RegIdxBits   = 3;

  typedef enum logic [RegIdxBits-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  // per-lane status handed to the merge stage
  typedef struct packed {
    logic flat;     // direction component was zero
    logic outside;  // flat and origin outside the slab
  } lane_stat_t;

endpackage

/* sv/ray_box_slab_intersect_top.sv */
// ray against configured box, slab test, three lanes and a merge stage
//   channel  | direction | fields
//   s_axis   | in        | origin xyz, dir xyz, t_start, t_end
//   m_axis   | out       | hit, t_enter, t_exit
//   cfg      | in        | box corner write
// one ray per cycle sustained while the output is not stalled
// the pipelined dividers (one quotient bit per stage) set the pipeline depth
// the whole pipeline advances when the output register is free or taken
// reset clears valids and box registers; no clearing pass
module ray_box_slab_intersect_top import rbsi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_start, t_end
  input  logic [8*CoordBits-1:0]      s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // t_enter, t_exit
  output logic [2*CoordBits-1:0]      m_axis_tdata,
  // hit
  output logic                        m_axis_tuser,
  input  logic                        cfg_we_i,
  input  logic [RegIdxBits-1:0]       cfg_idx_i,
  input  logic [CoordBits-1:0]        cfg_data_i
);

  localparam int unsigned Latency = CoordBits + 1 + FracBits + 1;

  logic [CoordBits-1:0] box_q [NumRegs];
  logic en;
  logic [Latency-1:0] vld_q;
  logic [CoordBits-1:0] t0_q [Latency];
  logic [CoordBits-1:0] t1_q [Latency];
  logic signed [CoordBits-1:0] tn [NumAxes];
  logic signed [CoordBits-1:0] tf [NumAxes];
  lane_stat_t stat [NumAxes];
  logic hit;
  logic signed [CoordBits-1:0] te, tx;
  logic out_vld_q, out_hit_q;
  logic [2*CoordBits-1:0] out_data_q;

  // box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) box_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_X: box_q[0] <= cfg_data_i;
        REG_MIN_Y: box_q[1] <= cfg_data_i;
        REG_MIN_Z: box_q[2] <= cfg_data_i;
        REG_MAX_X: box_q[3] <= cfg_data_i;
        REG_MAX_Y: box_q[4] <= cfg_data_i;
        REG_MAX_Z: box_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances when the output slot frees up
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Latency-2:0], s_axis_tvalid};
  end

  // interval bounds ride alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q[0] <= s_axis_tdata[6*CoordBits +: CoordBits];
      t1_q[0] <= s_axis_tdata[7*CoordBits +: CoordBits];
      for (int i = 1; i < Latency; i++) begin
        t0_q[i] <= t0_q[i-1];
        t1_q[i] <= t1_q[i-1];
      end
    end
  end

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    rbsi_lane #(.CoordBits(CoordBits), .Latency(Latency)) u_lane (
      .clk_i, .rst_ni, .en_i(en),
      .org_i(s_axis_tdata[a*CoordBits +: CoordBits]),
      .dir_i(s_axis_tdata[(3+a)*CoordBits +: CoordBits]),
      .pa_i(box_q[a]), .pb_i(box_q[3+a]),
      .tn_o(tn[a]), .tf_o(tf[a]), .stat_o(stat[a])
    );
  end

  rbsi_merge #(.CoordBits(CoordBits)) u_merge (
    .t0_i(t0_q[Latency-1]), .t1_i(t1_q[Latency-1]),
    .tn_i(tn), .tf_i(tf), .stat_i(stat),
    .hit_o(hit), .t_enter_o(te), .t_exit_o(tx)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vld_q[Latency-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q  <= hit;
      out_data_q <= {tx, te};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0) else $error("miss not zero");
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
    $signed(m_axis_tdata[CoordBits-1:0]) <= $signed(m_axis_tdata[2*CoordBits-1:CoordBits]))
    else $error("enter after exit");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved during stall");
`endif

endmodule

/* sv/rbsi_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module rbsi_div import rbsi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic signed [CoordBits:0]   num_i,   // plane minus origin, exact
  input  logic signed [CoordBits-1:0] den_i,   // nonzero unless ignored
  output logic signed [CoordBits-1:0] quot_o
);

  localparam int unsigned NumW  = CoordBits + 1 + FracBits;  // dividend magnitude width
  localparam int unsigned DenW  = CoordBits;
  localparam int unsigned Steps = NumW;
  localparam int unsigned RemW  = DenW + 1;

  logic [NumW-1:0] num_q  [Steps+1];
  logic [NumW-1:0] quo_q  [Steps+1];
  logic [RemW-1:0] rem_q  [Steps+1];
  logic [DenW-1:0] den_q  [Steps+1];
  logic            neg_q  [Steps+1];

  logic [CoordBits:0]   nmag;
  logic [CoordBits-1:0] dmag;

  assign nmag = num_i[CoordBits] ? CoordBits'(1) + ~num_i : num_i;
  assign dmag = den_i[CoordBits-1] ? ~den_i + CoordBits'(1) : den_i;

  // stage zero: magnitudes and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= {nmag, {FracBits{1'b0}}};
      quo_q[0] <= '0;
      rem_q[0] <= '0;
      den_q[0] <= dmag;
      neg_q[0] <= num_i[CoordBits] ^ den_i[CoordBits-1];
    end
  end

  // one restoring step per stage
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW:0] sh;
    logic [RemW:0] df;
    assign sh = {rem_q[s], num_q[s][NumW-1]};
    assign df = sh - {2'b00, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= {num_q[s][NumW-2:0], 1'b0};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (!df[RemW]) begin
          rem_q[s+1] <= df[RemW-1:0];
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= sh[RemW-1:0];
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // saturate and apply sign
  logic [NumW-1:0] q;
  logic [NumW-1:0] cap;
  logic [NumW-1:0] m;
  assign q   = quo_q[Steps];
  assign cap = neg_q[Steps] ? (NumW'(1) << (CoordBits-1)) : ((NumW'(1) << (CoordBits-1)) - 1'b1);
  assign m   = (q > cap) ? cap : q;
  assign quot_o = neg_q[Steps] ? (~m[CoordBits-1:0] + CoordBits'(1)) : m[CoordBits-1:0];

endmodule

/* sv/rbsi_lane.sv */
// one axis lane: two slab distances, ordered, plus zero-direction slab check
module rbsi_lane import rbsi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned Latency   = CoordBits + 1 + FracBits + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic signed [CoordBits-1:0] org_i,
  input  logic signed [CoordBits-1:0] dir_i,
  input  logic signed [CoordBits-1:0] pa_i,
  input  logic signed [CoordBits-1:0] pb_i,
  output logic signed [CoordBits-1:0] tn_o,
  output logic signed [CoordBits-1:0] tf_o,
  output lane_stat_t                  stat_o
);

  logic signed [CoordBits:0] na, nb;
  logic signed [CoordBits-1:0] qa, qb;
  lane_stat_t stat_d;
  lane_stat_t dly_q [Latency];
  logic signed [CoordBits-1:0] lo, hi;

  assign na = {pa_i[CoordBits-1], pa_i} - {org_i[CoordBits-1], org_i};
  assign nb = {pb_i[CoordBits-1], pb_i} - {org_i[CoordBits-1], org_i};

  rbsi_div #(.CoordBits(CoordBits)) u_div_a (
    .clk_i, .rst_ni, .en_i, .num_i(na), .den_i(dir_i), .quot_o(qa)
  );
  rbsi_div #(.CoordBits(CoordBits)) u_div_b (
    .clk_i, .rst_ni, .en_i, .num_i(nb), .den_i(dir_i), .quot_o(qb)
  );

  // closed slab test for a zero direction
  assign lo = (pa_i < pb_i) ? pa_i : pb_i;
  assign hi = (pa_i < pb_i) ? pb_i : pa_i;
  assign stat_d.flat    = (dir_i == '0);
  assign stat_d.outside = (dir_i == '0) && ((org_i < lo) || (org_i > hi));

  // status delay line matched to the divider
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= stat_d;
      for (int i = 1; i < Latency; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign stat_o = dly_q[Latency-1];
  assign tn_o   = (qa > qb) ? qb : qa;
  assign tf_o   = (qa > qb) ? qa : qb;

endmodule

/* sv/rbsi_merge.sv */
// merge stage: narrow the interval across the three lanes
module rbsi_merge import rbsi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic signed [CoordBits-1:0] t0_i,
  input  logic signed [CoordBits-1:0] t1_i,
  input  logic signed [CoordBits-1:0] tn_i [NumAxes],
  input  logic signed [CoordBits-1:0] tf_i [NumAxes],
  input  lane_stat_t                  stat_i [NumAxes],
  output logic                        hit_o,
  output logic signed [CoordBits-1:0] t_enter_o,
  output logic signed [CoordBits-1:0] t_exit_o
);

  // axes in order, the interval checked after each
  always_comb begin
    logic signed [CoordBits-1:0] a, b;
    logic miss;
    a = t0_i;
    b = t1_i;
    miss = 1'b0;
    for (int i = 0; i < NumAxes; i++) begin
      if (stat_i[i].outside) miss = 1'b1;
      if (!stat_i[i].flat) begin
        if (tn_i[i] > a) a = tn_i[i];
        if (tf_i[i] < b) b = tf_i[i];
      end
      if (a > b) miss = 1'b1;
    end
    hit_o     = !miss;
    t_enter_o = miss ? '0 : a;
    t_exit_o  = miss ? '0 : b;
  end

endmodule
